[src/poxr_pkg.sv]
package poxr_pkg;

    localparam int AVG_DEPTH_DEF     = 4;
    localparam int PULSE_DEPTH_DEF   = 64;
    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int LEVEL_W  = 12;
    localparam int TIME_W   = 32;
    localparam int RATIO_W  = 16;
    localparam int SPO2_W   = 16;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 88;
    localparam int OUT_USER_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPO2_SLOPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPO2_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_PRESENT = 3'd4;

    localparam logic [9:0]         WINDOW_RST = 10'd20;
    localparam logic [7:0]         THR_RST    = 8'd5;
    localparam logic signed [15:0] SLOPE_RST  = -16'sd4864;
    localparam logic signed [15:0] OFFSET_RST = 16'sd28672;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 12'd4095;
    localparam logic [RATIO_W-1:0] RATIO_SAT  = 16'hFFFF;
    localparam logic [7:0]         RUN_SAT    = 8'd255;

    localparam int RATIO_NUM_W = 36;
    localparam int DVS_W       = 24;

endpackage

[src/pulse_oximeter_ratio_tracker.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: ir_level, red_level, time_ms
// m_axis    out        tdata: ir_average, red_average, ratio_q12, beat_period, spo2_q8
//                      tuser: ratio_updated, beat_seen, spo2_updated
// cfg       in         write enable, register index, write data
//
// One item at a time. Each item updates the sample ring and both averages; when due, which is
// every item until the first beat sets a target, the pulse window is scanned and the ratio is
// divided; a beat sums the history and divides it for the new target; SpO2 is updated by a
// multiply and an add. DIV_W is at least 36; the shared radix-2 divider, one quotient bit per
// cycle, serves both divisions. After reset a clearing pass over max(PULSE_DEPTH, AVG_DEPTH,
// HISTORY_DEPTH) entries runs before the first transfer is accepted. A stalled result is held
// in the output register while the next item is accepted and worked on.
module pulse_oximeter_ratio_tracker #(
    parameter int AVG_DEPTH     = poxr_pkg::AVG_DEPTH_DEF,
    parameter int PULSE_DEPTH   = poxr_pkg::PULSE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = poxr_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // ir_level, red_level, time_ms
    input  logic [poxr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // ir_average, red_average, ratio_q12, beat_period, spo2_q8
    output logic [poxr_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // ratio_updated, beat_seen, spo2_updated
    output logic [poxr_pkg::OUT_USER_W-1:0]   o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [poxr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [poxr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import poxr_pkg::*;

    localparam int AA_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int PA_W   = $clog2(PULSE_DEPTH);
    localparam int HA_W   = $clog2(HISTORY_DEPTH);
    localparam int AS_W   = LEVEL_W + $clog2(AVG_DEPTH);
    localparam int HS_W   = TIME_W + $clog2(HISTORY_DEPTH);
    localparam int DIV_W  = (HS_W > RATIO_NUM_W) ? HS_W : RATIO_NUM_W;
    localparam int DC_W   = $clog2(DIV_W);
    localparam int CLR_A  = (PULSE_DEPTH > AVG_DEPTH) ? PULSE_DEPTH : AVG_DEPTH;
    localparam int CLR_N  = (CLR_A > HISTORY_DEPTH) ? CLR_A : HISTORY_DEPTH;
    localparam int CC_W   = $clog2(CLR_N);
    localparam int GD_W   = $clog2(HISTORY_DEPTH);
    localparam int RCP_S  = AS_W + $clog2(AVG_DEPTH);
    localparam int AP_W   = AS_W + RCP_S + 1;
    localparam logic [RCP_S:0] RCP_M =
        (RCP_S+1)'(((64'd1 << RCP_S) + 64'(AVG_DEPTH - 1)) / 64'(AVG_DEPTH));

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RING = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_AVGI = 4'd4;
    localparam logic [3:0] ST_AVGR = 4'd5;
    localparam logic [3:0] ST_SCAN = 4'd6;
    localparam logic [3:0] ST_RMUL = 4'd7;
    localparam logic [3:0] ST_RDIV = 4'd8;
    localparam logic [3:0] ST_BEAT = 4'd9;
    localparam logic [3:0] ST_HSUM = 4'd10;
    localparam logic [3:0] ST_TGT  = 4'd11;
    localparam logic [3:0] ST_SMUL = 4'd12;
    localparam logic [3:0] ST_SADD = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0] r_state, r_ret;

    logic [9:0]         r_window;
    logic [7:0]         r_thr;
    logic signed [15:0] r_slope, r_offset;
    logic               r_finger;

    logic [2*LEVEL_W-1:0] mem_ring [AVG_DEPTH];
    logic [2*LEVEL_W-1:0] mem_pulse [PULSE_DEPTH];
    logic [TIME_W-1:0]    mem_hist [HISTORY_DEPTH];
    logic [2*LEVEL_W-1:0] r_ring_rd, r_pm_rd, rm_wdata, pm_wdata;
    logic [TIME_W-1:0]    r_hm_rd, hm_wdata;
    logic                 rm_we, pm_we, hm_we;
    logic [AA_W-1:0]      rm_waddr, rm_raddr;
    logic [PA_W-1:0]      pm_waddr, pm_raddr;
    logic [HA_W-1:0]      hm_waddr, hm_raddr;

    logic [AA_W-1:0]    r_ring_pos;
    logic [AS_W-1:0]    r_ir_sum, r_red_sum;
    logic [PA_W-1:0]    r_pulse_pos;
    logic [15:0]        r_pulse_cnt, r_target;
    logic [RATIO_W-1:0] r_ratio;
    logic [HA_W-1:0]    r_hpos;
    logic [TIME_W-1:0]  r_last;
    logic [LEVEL_W-1:0] r_prev_ir;
    logic [7:0]         r_rise_run;
    logic               r_rising;
    logic signed [SPO2_W-1:0] r_spo2;

    logic [LEVEL_W-1:0] r_in_ir, r_in_red, r_ir_avg, r_red_avg;
    logic [TIME_W-1:0]  r_in_time, r_period;
    logic               r_rupd, r_beat, r_supd;

    logic [PA_W:0]      r_scnt;
    logic [LEVEL_W-1:0] r_imax, r_imin, r_rmax, r_rmin;
    logic               r_ifound, r_rfound;

    logic [HA_W:0]      r_hcnt;
    logic [HS_W-1:0]    r_hsum;
    logic [TIME_W-1:0]  r_hprev;
    logic [GD_W-1:0]    r_good;

    logic [DIV_W-1:0]   r_dnum;
    logic [DVS_W-1:0]   r_dden;
    logic [DVS_W:0]     r_drem;
    logic [DC_W-1:0]    r_dcnt;

    logic signed [32:0] r_sprod;
    logic [CC_W-1:0]    r_ccnt;

    logic                    r_ovalid;
    logic [OUT_DATA_W-1:0]   r_otdata;
    logic [OUT_USER_W-1:0]   r_otuser;

    logic [AS_W-1:0]    n_ir_sum, n_red_sum;
    logic [AS_W-1:0]    avg_src;
    logic [AP_W-1:0]    avg_prod;
    logic [LEVEL_W-1:0] avg_q;
    logic [DVS_W:0]     rem_sh, rem_nx;
    logic               q_bit;
    logic [DIV_W-1:0]   num_nx;
    logic [15:0]        cnt_inc;
    logic [LEVEL_W-1:0] sc_a, sc_b, iac, rac;
    logic [7:0]         run_inc;
    logic               beat_hit;
    logic [TIME_W+3:0]  p10, p11, q10, q11;
    logic               pair_good;
    logic [9:0]         w_eff;
    logic signed [20:0] sp_floor;
    logic signed [21:0] sp_sum;
    logic [DIV_W-1:0]   quot;
    logic [RATIO_W-1:0] quot_sat;
    logic               s_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_otdata;
    assign o_m_tuser  = r_otuser;

    assign n_ir_sum  = r_ir_sum - AS_W'(r_ring_rd[LEVEL_W-1:0]) + AS_W'(r_in_ir);
    assign n_red_sum = r_red_sum - AS_W'(r_ring_rd[2*LEVEL_W-1:LEVEL_W]) + AS_W'(r_in_red);

    assign avg_src  = (r_state == ST_AVGI) ? r_ir_sum : r_red_sum;
    assign avg_prod = AP_W'(avg_src) * AP_W'(RCP_M);
    assign avg_q    = avg_prod[RCP_S +: LEVEL_W];

    assign rem_sh = {r_drem[DVS_W-1:0], r_dnum[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dden});
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_dden}) : rem_sh;
    assign num_nx = {r_dnum[DIV_W-2:0], q_bit};
    assign quot     = r_dnum;
    assign quot_sat = (|quot[DIV_W-1:RATIO_W]) ? RATIO_SAT : quot[RATIO_W-1:0];

    assign cnt_inc = (r_pulse_cnt == 16'hFFFF) ? r_pulse_cnt : r_pulse_cnt + 16'd1;
    assign sc_a    = r_pm_rd[LEVEL_W-1:0];
    assign sc_b    = r_pm_rd[2*LEVEL_W-1:LEVEL_W];
    assign iac     = r_imax - r_imin;
    assign rac     = r_rmax - r_rmin;
    assign run_inc = (r_rise_run == RUN_SAT) ? r_rise_run : r_rise_run + 8'd1;
    assign w_eff   = (r_window == 10'd0) ? 10'd1 : r_window;
    assign beat_hit = r_finger && (r_ir_avg > r_prev_ir) && !r_rising && (run_inc > r_thr);

    assign p10 = (TIME_W+4)'(r_hm_rd) * (TIME_W+4)'(10);
    assign p11 = (TIME_W+4)'(r_hm_rd) * (TIME_W+4)'(11);
    assign q10 = (TIME_W+4)'(r_hprev) * (TIME_W+4)'(10);
    assign q11 = (TIME_W+4)'(r_hprev) * (TIME_W+4)'(11);
    assign pair_good = (p10 < q11) && (p11 > q10);

    assign sp_floor = r_sprod[32:12];
    assign sp_sum   = 22'(sp_floor) + 22'(r_offset);

    always_comb begin
        rm_we    = 1'b0;
        rm_waddr = r_ring_pos;
        rm_wdata = {r_in_red, r_in_ir};
        rm_raddr = r_ring_pos;
        pm_we    = 1'b0;
        pm_waddr = r_pulse_pos;
        pm_wdata = {avg_q, r_ir_avg};
        pm_raddr = (r_scnt < (PA_W+1)'(PULSE_DEPTH)) ? r_scnt[PA_W-1:0] : '0;
        hm_we    = 1'b0;
        hm_waddr = r_hpos;
        hm_wdata = r_in_time - r_last;
        hm_raddr = (r_hcnt < (HA_W+1)'(HISTORY_DEPTH)) ? r_hcnt[HA_W-1:0] : '0;
        case (r_state)
            ST_CLR: begin
                rm_we    = ({1'b0, r_ccnt} < (CC_W+1)'(AVG_DEPTH));
                rm_waddr = r_ccnt[AA_W-1:0];
                rm_wdata = '0;
                pm_we    = ({1'b0, r_ccnt} < (CC_W+1)'(PULSE_DEPTH));
                pm_waddr = r_ccnt[PA_W-1:0];
                pm_wdata = '0;
                hm_we    = ({1'b0, r_ccnt} < (CC_W+1)'(HISTORY_DEPTH));
                hm_waddr = r_ccnt[HA_W-1:0];
                hm_wdata = '0;
            end
            ST_RING: rm_we = 1'b1;
            ST_AVGR: pm_we = 1'b1;
            ST_SCAN: begin
                pm_we    = (r_scnt != '0);
                pm_waddr = PA_W'(r_scnt - (PA_W+1)'(1));
                pm_wdata = '0;
            end
            ST_BEAT: hm_we = beat_hit;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) begin
            mem_ring[rm_waddr] <= rm_wdata;
        end
        r_ring_rd <= mem_ring[rm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            mem_pulse[pm_waddr] <= pm_wdata;
        end
        r_pm_rd <= mem_pulse[pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hm_we) begin
            mem_hist[hm_waddr] <= hm_wdata;
        end
        r_hm_rd <= mem_hist[hm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_thr    <= THR_RST;
            r_slope  <= SLOPE_RST;
            r_offset <= OFFSET_RST;
            r_finger <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_MS:      r_window <= i_cfg_data[9:0];
                CFG_RISE_THRESHOLD: r_thr    <= i_cfg_data[7:0];
                CFG_SPO2_SLOPE:     r_slope  <= $signed(i_cfg_data);
                CFG_SPO2_OFFSET:    r_offset <= $signed(i_cfg_data);
                CFG_FINGER_PRESENT: r_finger <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_ret       <= ST_IDLE;
            r_ccnt      <= '0;
            r_ring_pos  <= '0;
            r_ir_sum    <= '0;
            r_red_sum   <= '0;
            r_pulse_pos <= '0;
            r_pulse_cnt <= '0;
            r_target    <= '0;
            r_ratio     <= '0;
            r_hpos      <= '0;
            r_last      <= '0;
            r_prev_ir   <= '0;
            r_rise_run  <= '0;
            r_rising    <= 1'b0;
            r_spo2      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_ccnt <= r_ccnt + CC_W'(1);
                    if (r_ccnt == CC_W'(CLR_N - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        r_in_ir   <= i_s_tdata[11:0];
                        r_in_red  <= i_s_tdata[23:12];
                        r_in_time <= i_s_tdata[55:24];
                        r_rupd    <= 1'b0;
                        r_beat    <= 1'b0;
                        r_period  <= '0;
                        r_supd    <= 1'b0;
                        r_state   <= ST_RING;
                    end
                end
                ST_RING: begin
                    r_ir_sum   <= n_ir_sum;
                    r_red_sum  <= n_red_sum;
                    r_ring_pos <= (r_ring_pos == AA_W'(AVG_DEPTH - 1)) ? '0
                                  : r_ring_pos + AA_W'(1);
                    r_state <= ST_AVGI;
                end
                ST_DIV: begin
                    r_dnum <= num_nx;
                    r_drem <= rem_nx;
                    r_dcnt <= r_dcnt + DC_W'(1);
                    if (r_dcnt == DC_W'(DIV_W - 1)) begin
                        r_state <= r_ret;
                    end
                end
                ST_AVGI: begin
                    r_ir_avg <= avg_q;
                    r_state  <= ST_AVGR;
                end
                ST_AVGR: begin
                    r_red_avg   <= avg_q;
                    r_pulse_pos <= (r_pulse_pos == PA_W'(PULSE_DEPTH - 1)) ? '0
                                   : r_pulse_pos + PA_W'(1);
                    if (cnt_inc >= r_target) begin
                        r_pulse_cnt <= '0;
                        r_rupd      <= 1'b1;
                        r_scnt      <= '0;
                        r_imax      <= '0;
                        r_rmax      <= '0;
                        r_imin      <= LEVEL_FULL;
                        r_rmin      <= LEVEL_FULL;
                        r_ifound    <= 1'b0;
                        r_rfound    <= 1'b0;
                        r_state     <= ST_SCAN;
                    end else begin
                        r_pulse_cnt <= cnt_inc;
                        r_state     <= ST_BEAT;
                    end
                end
                ST_SCAN: begin
                    r_scnt <= r_scnt + (PA_W+1)'(1);
                    if (r_scnt != '0) begin
                        if (sc_a > r_imax) r_imax <= sc_a;
                        if (sc_b > r_rmax) r_rmax <= sc_b;
                        if ((sc_a != '0) && (sc_a <= r_imin)) begin
                            r_imin   <= sc_a;
                            r_ifound <= 1'b1;
                        end
                        if ((sc_b != '0) && (sc_b <= r_rmin)) begin
                            r_rmin   <= sc_b;
                            r_rfound <= 1'b1;
                        end
                    end
                    if (r_scnt == (PA_W+1)'(PULSE_DEPTH)) begin
                        r_state <= ST_RMUL;
                    end
                end
                ST_RMUL: begin
                    if (!r_ifound || !r_rfound || (iac == '0) || (rac == '0)) begin
                        r_ratio <= RATIO_SAT;
                        r_state <= ST_BEAT;
                    end else begin
                        r_dnum  <= DIV_W'({(2*LEVEL_W)'(rac) * (2*LEVEL_W)'(r_imin), 12'd0});
                        r_dden  <= DVS_W'(r_rmin) * DVS_W'(iac);
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= ST_RDIV;
                        r_state <= ST_DIV;
                    end
                end
                ST_RDIV: begin
                    r_ratio <= quot_sat;
                    r_state <= ST_BEAT;
                end
                ST_BEAT: begin
                    r_state <= beat_hit ? ST_HSUM : ST_DONE;
                    if (r_finger) begin
                        r_prev_ir <= r_ir_avg;
                        if (r_ir_avg > r_prev_ir) begin
                            r_rise_run <= run_inc;
                            if (beat_hit) begin
                                r_rising <= 1'b1;
                                r_beat   <= 1'b1;
                                r_period <= r_in_time - r_last;
                                r_last   <= r_in_time;
                                r_hcnt   <= '0;
                                r_hsum   <= '0;
                                r_good   <= '0;
                            end
                        end else begin
                            r_rising   <= 1'b0;
                            r_rise_run <= '0;
                        end
                    end
                end
                ST_HSUM: begin
                    r_hcnt <= r_hcnt + (HA_W+1)'(1);
                    if (r_hcnt != '0) begin
                        r_hsum  <= r_hsum + HS_W'(r_hm_rd);
                        r_hprev <= r_hm_rd;
                        if ((r_hcnt != (HA_W+1)'(1)) && pair_good) begin
                            r_good <= r_good + GD_W'(1);
                        end
                    end
                    if (r_hcnt == (HA_W+1)'(HISTORY_DEPTH)) begin
                        r_hpos  <= (r_hpos == HA_W'(HISTORY_DEPTH - 1)) ? '0
                                   : r_hpos + HA_W'(1);
                        r_dnum  <= DIV_W'(r_hsum + HS_W'(r_hm_rd));
                        r_dden  <= DVS_W'(w_eff) * DVS_W'(2 * HISTORY_DEPTH);
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= ST_TGT;
                        r_state <= ST_DIV;
                    end
                end
                ST_TGT: begin
                    r_target <= quot_sat;
                    r_state  <= (r_good > GD_W'(1)) ? ST_SMUL : ST_DONE;
                end
                ST_SMUL: begin
                    r_sprod <= r_slope * $signed({1'b0, r_ratio});
                    r_state <= ST_SADD;
                end
                ST_SADD: begin
                    if (sp_sum > 22'sd32767) begin
                        r_spo2 <= 16'sh7FFF;
                    end else if (sp_sum < -22'sd32768) begin
                        r_spo2 <= -16'sh8000;
                    end else begin
                        r_spo2 <= sp_sum[15:0];
                    end
                    r_supd  <= 1'b1;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_otdata <= {r_spo2, r_period, r_ratio, r_red_avg, r_ir_avg};
                        r_otuser <= {r_supd, r_beat, r_rupd};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[71:40] == '0))
        else $error("beat period set without a beat");

    a_spo2_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> o_m_tuser[1])
        else $error("SpO2 update without a beat");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_drem < {1'b0, r_dden}))
        else $error("divider remainder out of range");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_s_tready)
        else $error("transfer accepted during clearing pass");

endmodule

[sim/pulse_oximeter_ratio_tracker_test.sv]
module pulse_oximeter_ratio_tracker_test;
    import poxr_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [11:0] red;
        logic [11:0] ir;
    } sample_t;

    typedef struct packed {
        logic [15:0] spo2;
        logic [31:0] period;
        logic [15:0] ratio;
        logic [11:0] red_avg;
        logic [11:0] ir_avg;
        logic        spo2_upd;
        logic        beat;
        logic        ratio_upd;
    } reading_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_tvalid = 0;
    logic o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pulse_oximeter_ratio_tracker dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state.
    logic [9:0] win_ms;
    logic [7:0] rise_thr;
    logic [15:0] slope, offset;
    logic finger;
    logic [11:0] ir_ring [4], red_ring [4];
    logic [13:0] ir_sum, red_sum;
    logic [1:0] ring_pos;
    logic [11:0] ir_store [64], red_store [64];
    logic [5:0] store_pos;
    logic [15:0] store_count, store_target, ratio_val;
    logic [31:0] period_hist [8];
    logic [15:0] ratio_hist [8];
    logic [2:0] hist_pos;
    logic [31:0] prev_beat_ms;
    logic [11:0] prev_ir;
    logic [7:0] rise_run;
    logic rising;
    logic [15:0] spo2_val;

    sample_t pending[$];
    reading_t readings_due[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    int drv_gap = 0, rcv_gap = 0;

    task automatic reset_predictor();
        win_ms = WINDOW_RST; rise_thr = THR_RST; slope = SLOPE_RST; offset = OFFSET_RST;
        finger = 1;
        foreach (ir_ring[i]) begin ir_ring[i] = 0; red_ring[i] = 0; end
        ir_sum = 0; red_sum = 0; ring_pos = 0;
        foreach (ir_store[i]) begin ir_store[i] = 0; red_store[i] = 0; end
        store_pos = 0; store_count = 0; store_target = 0; ratio_val = 0;
        foreach (period_hist[i]) begin period_hist[i] = 0; ratio_hist[i] = 0; end
        hist_pos = 0; prev_beat_ms = 0; prev_ir = 0; rise_run = 0; rising = 0; spo2_val = 0;
    endtask

    function automatic logic [15:0] scan_ratio();
        logic [11:0] imax, imin, rmax, rmin;
        bit ifound, rfound;
        logic [63:0] iac, rac, num, den, q;
        imax = 0; imin = LEVEL_FULL; rmax = 0; rmin = LEVEL_FULL;
        ifound = 0; rfound = 0;
        for (int i = 0; i < 64; i++) begin
            if (ir_store[i] > imax) imax = ir_store[i];
            if (ir_store[i] != 0 && ir_store[i] <= imin) begin
                imin = ir_store[i]; ifound = 1;
            end
            if (red_store[i] > rmax) rmax = red_store[i];
            if (red_store[i] != 0 && red_store[i] <= rmin) begin
                rmin = red_store[i]; rfound = 1;
            end
            ir_store[i] = 0; red_store[i] = 0;
        end
        if (!ifound || !rfound) return RATIO_SAT;
        iac = imax - imin; rac = rmax - rmin;
        if (iac == 0 || rac == 0) return RATIO_SAT;
        num = (rac * imin) << 12;
        den = rmin * iac;
        q = num / den;
        return (q > 65535) ? RATIO_SAT : q[15:0];
    endfunction

    function automatic logic [15:0] calibrate_spo2();
        longint p, f, s;
        p = longint'($signed(slope)) * longint'(ratio_val);
        f = p >>> 12;
        s = f + longint'($signed(offset));
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    function automatic reading_t predict_reading(sample_t s);
        reading_t r;
        logic [11:0] ir_avg, red_avg;
        logic [63:0] sum, mean, tgt, p, q;
        logic [10:0] w;
        int good;
        r = '0;
        ir_sum = ir_sum - ir_ring[ring_pos] + s.ir;
        red_sum = red_sum - red_ring[ring_pos] + s.red;
        ir_ring[ring_pos] = s.ir; red_ring[ring_pos] = s.red;
        ir_avg = ir_sum >> 2; red_avg = red_sum >> 2;
        ir_store[store_pos] = ir_avg; red_store[store_pos] = red_avg;
        store_pos++;
        if (store_count != 16'hFFFF) store_count++;
        if (store_count >= store_target) begin
            store_count = 0;
            ratio_val = scan_ratio();
            r.ratio_upd = 1;
        end
        if (finger) begin
            if (ir_avg > prev_ir) begin
                if (rise_run != RUN_SAT) rise_run++;
                if (!rising && rise_run > rise_thr) begin
                    rising = 1; r.beat = 1;
                    r.period = s.time_ms - prev_beat_ms;
                    ratio_hist[hist_pos] = ratio_val;
                    period_hist[hist_pos] = r.period;
                    prev_beat_ms = s.time_ms;
                    sum = 0;
                    foreach (period_hist[i]) sum += period_hist[i];
                    mean = sum / 8;
                    w = (win_ms == 0) ? 11'd1 : {1'b0, win_ms};
                    tgt = mean / (2 * w);
                    store_target = (tgt > 65535) ? 16'hFFFF : tgt[15:0];
                    good = 0;
                    for (int i = 1; i < 8; i++) begin
                        p = period_hist[i]; q = period_hist[i-1];
                        if (10 * p < 11 * q && 11 * p > 10 * q) good++;
                    end
                    hist_pos++;
                    if (good > 1) begin
                        spo2_val = calibrate_spo2();
                        r.spo2_upd = 1;
                    end
                end
            end else begin
                rising = 0; rise_run = 0;
            end
            prev_ir = ir_avg;
        end
        ring_pos++;
        r.ir_avg = ir_avg; r.red_avg = red_avg; r.ratio = ratio_val; r.spo2 = spo2_val;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) readings_due.push_back(predict_reading(i_s_tdata));
        if (!i_s_tvalid || o_s_tready) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                i_s_tvalid <= 0;
            end else if (pending.size() > 0) begin
                i_s_tvalid <= 1;
                i_s_tdata <= pending.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 3);
            end else begin
                i_s_tvalid <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        reading_t got, want;
        if (o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[87:0], o_m_tuser};
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
            end else begin
                want = readings_due.pop_front();
                if (got.ir_avg !== want.ir_avg)
                    $display("%0t: ir_average expected %0d actual %0d",
                             $time, want.ir_avg, got.ir_avg);
                if (got.red_avg !== want.red_avg)
                    $display("%0t: red_average expected %0d actual %0d",
                             $time, want.red_avg, got.red_avg);
                if (got.ratio !== want.ratio)
                    $display("%0t: ratio_q12 expected %0d actual %0d",
                             $time, want.ratio, got.ratio);
                if (got.period !== want.period)
                    $display("%0t: beat_period expected %0d actual %0d",
                             $time, want.period, got.period);
                if (got.spo2 !== want.spo2)
                    $display("%0t: spo2_q8 expected %0d actual %0d",
                             $time, want.spo2, got.spo2);
                if (got.ratio_upd !== want.ratio_upd)
                    $display("%0t: ratio_updated expected %0d actual %0d",
                             $time, want.ratio_upd, got.ratio_upd);
                if (got.beat !== want.beat)
                    $display("%0t: beat_seen expected %0d actual %0d",
                             $time, want.beat, got.beat);
                if (got.spo2_upd !== want.spo2_upd)
                    $display("%0t: spo2_updated expected %0d actual %0d",
                             $time, want.spo2_upd, got.spo2_upd);
                if (got !== want) errors++;
            end
        end
        if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
            if (!quiet && $urandom_range(0, 5) == 0) rcv_gap <= $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_WINDOW_MS: win_ms = val[9:0];
            CFG_RISE_THRESHOLD: rise_thr = val[7:0];
            CFG_SPO2_SLOPE: slope = val;
            CFG_SPO2_OFFSET: offset = val;
            CFG_FINGER_PRESENT: finger = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending.size() > 0 || readings_due.size() > 0 || i_s_tvalid) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    // Pulses: rising IR ramps of random length with random base levels, each followed by four low samples.
    task automatic queue_pulses(int count, int period_ms);
        logic [31:0] t;
        int len, base;
        t = $urandom;
        for (int n = 0; n < count; ) begin
            len = $urandom_range(3, 14);
            base = $urandom_range(0, 3000);
            for (int k = 0; k < len && n < count; k++, n++) begin
                pending.push_back({t, 12'($urandom_range(base, base + 1000)),
                                   12'(base + k * $urandom_range(10, 70))});
                t += period_ms / len;
            end
            for (int k = 0; k < 4 && n < count; k++, n++) begin
                pending.push_back({t, 12'($urandom), 12'(base / 2)});
                t += 5;
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        pending.push_back({32'd0, 12'd0, 12'd0});
        pending.push_back({32'hFFFFFFFF, 12'hFFF, 12'hFFF});
        pending.push_back({32'h0, 12'hFFF, 12'hFFF});
        pending.push_back({32'h12345, 12'h800, 12'hFFF});
        for (int i = 0; i < 10; i++)
            pending.push_back({32'(i * 40), 12'(100 + i * 300), 12'(200 + i * 350)});
        for (int i = 0; i < 6; i++) pending.push_back({32'(1000 + i), 12'd0, 12'd0});
        drain();
        write_reg(CFG_WINDOW_MS, 16'd1);
        write_reg(CFG_RISE_THRESHOLD, 16'd0);
        write_reg(CFG_SPO2_SLOPE, 16'h8000);
        write_reg(CFG_SPO2_OFFSET, 16'h7FFF);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        queue_pulses(150, 400);
        drain();
        write_reg(CFG_WINDOW_MS, 16'd0);
        write_reg(CFG_SPO2_SLOPE, 16'h7FFF);
        write_reg(CFG_SPO2_OFFSET, 16'h8000);
        write_reg(CFG_RISE_THRESHOLD, 16'd255);
        queue_pulses(150, 900);
        drain();
        write_reg(CFG_FINGER_PRESENT, 16'd0);
        write_reg(CFG_WINDOW_MS, 16'd1000);
        for (int i = 0; i < 100; i++) pending.push_back({32'($urandom), 24'($urandom)});
        drain();
        write_reg(CFG_FINGER_PRESENT, 16'd1);
        write_reg(CFG_WINDOW_MS, 16'd2);
        write_reg(CFG_RISE_THRESHOLD, 16'd2);
        write_reg(CFG_SPO2_SLOPE, 16'hED00);
        write_reg(CFG_SPO2_OFFSET, 16'd28672);
        queue_pulses(500, 800);
        for (int i = 0; i < 50; i++) pending.push_back({32'($urandom), 24'($urandom)});
        drain();
        write_reg(CFG_WINDOW_MS, 16'd7);
        write_reg(CFG_RISE_THRESHOLD, 16'd4);
        quiet = 1;
        queue_pulses(250, 700);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
